// ----- rtl/pow2_block_page_allocator_macros.svh -----
// pow2_block_page_allocator_macros.svh: assertion macros for the page allocator
// no dependencies; included by the files that carry assertions
`ifndef POW2_BLOCK_PAGE_ALLOCATOR_MACROS_SVH
`define POW2_BLOCK_PAGE_ALLOCATOR_MACROS_SVH

// implication or plain property, checked at every clock edge outside reset
`define PBPA_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// condition that must hold at every clock edge outside reset
`define PBPA_ASSERT_ALWAYS(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

`endif

// ----- rtl/pbpa_pkg.sv -----
// pbpa_pkg: field widths, codes, defaults and sequencer types of the page allocator
// no dependencies; used by the interfaces, the ram and the top level
`default_nettype none

package pbpa_pkg;

  // payload field widths
  localparam int OPCODE_W     = 2;
  localparam int SIZE_W       = 12;
  localparam int ADDR_W       = 32;
  localparam int BLOCK_SIZE_W = 12;
  localparam int STATUS_W     = 2;
  localparam int CFG_INDEX_W  = 2;
  localparam int CFG_DATA_W   = 32;
  localparam int PAGES_CFG_W  = 7;

  // default geometry
  localparam int DEF_PAGE_BYTES = 4096;
  localparam int DEF_MAX_PAGES  = 64;
  localparam int DEF_MIN_BLOCK  = 8;
  localparam int DEF_MAX_BLOCK  = 2048;
  localparam int DEF_RAM_WIDTH  = 16;

  // request opcodes
  localparam logic [OPCODE_W-1:0] OP_ALLOC = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_FREE  = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_QUERY = 2'd2;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_ZERO    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOFREE  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_INVALID = 2'd3;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_REGION_START = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_REGION_PAGES = 2'd1;

  // sequencer states
  typedef enum logic [4:0] {
    S_IDLE,
    S_DECODE,
    S_TH_RD,
    S_TH_DO,
    S_SP_RD,
    S_SP_SET,
    S_SP_PUSH,
    S_SP_END,
    S_FR_CHK,
    S_FR_PUSH1,
    S_FR_PUSH2,
    S_WK_START,
    S_WK_RD,
    S_WK_DO,
    S_WK_END,
    S_FIN
  } state_t;

  // which attempt of an allocation is taking a list head
  typedef enum logic [1:0] {
    PH_FIRST,
    PH_SPLIT,
    PH_LARGER
  } phase_t;

endpackage

`default_nettype wire

// ----- rtl/pbpa_req_if.sv -----
// pbpa_req_if: request channel of the page allocator
// depends on pbpa_pkg for field widths
`default_nettype none

interface pbpa_req_if;
  logic                              valid;
  logic                              ready;
  logic [pbpa_pkg::OPCODE_W-1:0]     opcode;
  logic [pbpa_pkg::SIZE_W-1:0]       request_size;
  logic [pbpa_pkg::ADDR_W-1:0]       address;

  modport source (output valid, opcode, request_size, address, input ready);
  modport sink   (input valid, opcode, request_size, address, output ready);
endinterface

`default_nettype wire

// ----- rtl/pbpa_rsp_if.sv -----
// pbpa_rsp_if: result channel of the page allocator
// depends on pbpa_pkg for field widths
`default_nettype none

interface pbpa_rsp_if;
  logic                              valid;
  logic                              ready;
  logic [pbpa_pkg::ADDR_W-1:0]       result_address;
  logic [pbpa_pkg::BLOCK_SIZE_W-1:0] block_size;
  logic [pbpa_pkg::STATUS_W-1:0]     status;

  modport source (output valid, result_address, block_size, status, input ready);
  modport sink   (input valid, result_address, block_size, status, output ready);
endinterface

`default_nettype wire

// ----- rtl/pbpa_cfg_if.sv -----
// pbpa_cfg_if: configuration write channel of the page allocator
// depends on pbpa_pkg for field widths
`default_nettype none

interface pbpa_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [pbpa_pkg::CFG_INDEX_W-1:0]  index;
  logic [pbpa_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- rtl/pbpa_ram.sv -----
// pbpa_ram: single write port, single read port memory with registered read data
// depends on pbpa_pkg for default sizes
`default_nettype none

module pbpa_ram #(
  parameter int DEPTH = pbpa_pkg::DEF_MAX_PAGES,
  parameter int WIDTH = pbpa_pkg::DEF_RAM_WIDTH
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, read data registered
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- rtl/pow2_block_page_allocator.sv -----
// Power-of-two block page allocator. One request is worked at a time and
// answered with exactly one result. An allocation is served from a class
// list when it has a block; else it splits a fresh page, pushing each of
// its blocks (up to PAGE_BYTES/MIN_BLOCK, 512 by default) onto the list,
// and else searches larger classes. A free that returns a whole page walks
// that class's free list. The link memories take one list update per cycle.
// Configuration writes rebuild all tables at once; there is no clearing pass.
// Depends on pbpa_pkg, the channel interfaces, pbpa_ram and the macro header.
`default_nettype none
`include "pow2_block_page_allocator_macros.svh"

module pow2_block_page_allocator #(
  parameter int PAGE_BYTES = pbpa_pkg::DEF_PAGE_BYTES,
  parameter int MAX_PAGES  = pbpa_pkg::DEF_MAX_PAGES,
  parameter int MIN_BLOCK  = pbpa_pkg::DEF_MIN_BLOCK,
  parameter int MAX_BLOCK  = pbpa_pkg::DEF_MAX_BLOCK
) (
  input logic          clk,
  input logic          rst,
  pbpa_req_if.sink     req,
  pbpa_rsp_if.source   rsp,
  pbpa_cfg_if.sink     cfg
);

  localparam int LOGP   = $clog2(PAGE_BYTES);
  localparam int LOGMIN = $clog2(MIN_BLOCK);
  localparam int LOGBPP = LOGP - LOGMIN;
  localparam int BPP    = PAGE_BYTES / MIN_BLOCK;
  localparam int TOTAL  = MAX_PAGES * BPP;
  localparam int BW     = $clog2(TOTAL + 1);
  localparam int BIW    = $clog2(TOTAL);
  localparam int PW     = $clog2(MAX_PAGES + 1);
  localparam int PIW    = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
  localparam int CW     = $clog2(BPP + 1);
  localparam int NCLASS = $clog2(MAX_BLOCK / MIN_BLOCK) + 1;
  localparam int KW     = $clog2(NCLASS);
  localparam int SW     = $clog2(MAX_BLOCK + 1);
  localparam int RECW   = SW + CW + PW;

  localparam logic [BW-1:0] NO_BLK = BW'(TOTAL);
  localparam logic [PW-1:0] NO_PG  = PW'(MAX_PAGES);

  pbpa_pkg::state_t state, state_next;
  pbpa_pkg::phase_t phase;

  // latched request
  logic [pbpa_pkg::OPCODE_W-1:0] op;
  logic [pbpa_pkg::SIZE_W-1:0]   size;
  logic [pbpa_pkg::ADDR_W-1:0]   addr;

  // configuration and list heads
  logic [31:0]       region_start;
  logic [PW-1:0]     region_pages;
  logic [PW-1:0]     fph;
  logic [MAX_PAGES-1:0] pg_vld;
  logic [BW-1:0]     head [NCLASS];
  logic [BW-1:0]     tail [NCLASS];

  // working registers
  logic [KW-1:0]     thk;
  logic [SW-1:0]     csz, lsz;
  logic [BW-1:0]     cur, pp, wcur, steps, blk, stride;
  logic [PIW-1:0]    pg, pg_ridx;
  logic [CW-1:0]     cnt, n;
  logic [31:0]       res_addr;
  logic [SW-1:0]     res_size;
  logic [pbpa_pkg::STATUS_W-1:0] status;

  // output register
  logic                              rsp_valid;
  logic [pbpa_pkg::ADDR_W-1:0]       out_addr;
  logic [pbpa_pkg::BLOCK_SIZE_W-1:0] out_size;
  logic [pbpa_pkg::STATUS_W-1:0]     out_status;

  // memory ports
  logic            nx_we, pv_we, pg_we;
  logic [BIW-1:0]  nx_waddr, pv_waddr, lk_raddr;
  logic [BW-1:0]   nx_wdata, pv_wdata, nd, pd;
  logic [PIW-1:0]  pg_waddr, pg_raddr;
  logic [RECW-1:0] pg_wdata, pg_rdata;

  // combinational helpers
  logic [31:0]     off, off_pg;
  logic [LOGP-1:0] off_in;
  logic [KW-1:0]   dec_k, fr_k;
  logic [SW-1:0]   dec_c;
  logic [SW-1:0]   pr_cls;
  logic [CW-1:0]   pr_cnt;
  logic [PW-1:0]   pr_link;
  logic [31:0]     fr_total;
  logic [BW-1:0]   hd, tl;
  logic            split_go, larger_go, rsp_load;
  logic [PW-1:0]   cfg_pages, rb_pages;

  function automatic logic [KW-1:0] class_of(input logic [31:0] v);
    logic [KW-1:0] r;
    r = KW'(NCLASS - 1);
    for (int j = NCLASS - 1; j >= 0; j--) begin
      if ((32'(MIN_BLOCK) << j) >= v) r = KW'(j);
    end
    return r;
  endfunction

  function automatic logic blk_ok(input logic [BW-1:0] b);
    return b < NO_BLK;
  endfunction

  function automatic logic [PIW-1:0] page_of(input logic [BW-1:0] b);
    return PIW'(b >> LOGBPP);
  endfunction

  // link and page memories
  pbpa_ram #(.DEPTH(TOTAL), .WIDTH(BW)) u_next_ram (
    .clk(clk), .we(nx_we), .waddr(nx_waddr), .wdata(nx_wdata),
    .raddr(lk_raddr), .rdata(nd)
  );

  pbpa_ram #(.DEPTH(TOTAL), .WIDTH(BW)) u_prev_ram (
    .clk(clk), .we(pv_we), .waddr(pv_waddr), .wdata(pv_wdata),
    .raddr(lk_raddr), .rdata(pd)
  );

  pbpa_ram #(.DEPTH(MAX_PAGES), .WIDTH(RECW)) u_page_ram (
    .clk(clk), .we(pg_we), .waddr(pg_waddr), .wdata(pg_wdata),
    .raddr(pg_raddr), .rdata(pg_rdata)
  );

  // page record view: a page never written reads as its rebuilt value
  always_comb begin
    if (pg_vld[pg_ridx]) begin
      {pr_cls, pr_cnt, pr_link} = pg_rdata;
    end else begin
      pr_cls = '0;
      pr_cnt = '0;
      if (32'(pg_ridx) + 32'd1 < 32'(region_pages)) begin
        pr_link = PW'(32'(pg_ridx) + 32'd1);
      end else begin
        pr_link = NO_PG;
      end
    end
  end

  // address decode and class helpers
  assign off      = addr - region_start;
  assign off_pg   = off >> LOGP;
  assign off_in   = off[LOGP-1:0];
  assign dec_k    = class_of(32'(size));
  assign dec_c    = SW'(32'(MIN_BLOCK) << dec_k);
  assign fr_k     = class_of(32'(pr_cls));
  assign fr_total = 32'(BPP) >> fr_k;
  assign hd       = head[thk];
  assign tl       = tail[thk];
  assign split_go = (phase == pbpa_pkg::PH_FIRST) && (32'(csz) <= 32'(PAGE_BYTES))
                    && (fph < NO_PG);
  assign larger_go = (32'(thk) + 32'd1) < 32'(NCLASS);
  assign rsp_load  = (state == pbpa_pkg::S_FIN) && (!rsp_valid || rsp.ready);

  // configuration values
  assign cfg_pages = (32'(cfg.data[pbpa_pkg::PAGES_CFG_W-1:0]) > 32'(MAX_PAGES)) ?
                     NO_PG : PW'(cfg.data[pbpa_pkg::PAGES_CFG_W-1:0]);
  assign rb_pages  = (cfg.index == pbpa_pkg::REG_REGION_PAGES) ? cfg_pages : region_pages;

  // handshake ports
  assign req.ready          = (state == pbpa_pkg::S_IDLE);
  assign cfg.ready          = 1'b1;
  assign rsp.valid          = rsp_valid;
  assign rsp.result_address = out_addr;
  assign rsp.block_size     = out_size;
  assign rsp.status         = out_status;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pbpa_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and memory ports
  always_comb begin
    state_next = state;
    lk_raddr   = BIW'(cur);
    nx_we      = 1'b0;
    nx_waddr   = BIW'(cur);
    nx_wdata   = NO_BLK;
    pv_we      = 1'b0;
    pv_waddr   = BIW'(cur);
    pv_wdata   = NO_BLK;
    pg_raddr   = pg;
    pg_we      = 1'b0;
    pg_waddr   = pg;
    pg_wdata   = '0;
    unique case (state)
      pbpa_pkg::S_IDLE: begin
        if (req.valid) state_next = pbpa_pkg::S_DECODE;
      end
      pbpa_pkg::S_DECODE: begin
        if (op == pbpa_pkg::OP_ALLOC) begin
          if (32'(size) > 32'(MAX_BLOCK) || size == '0) begin
            state_next = pbpa_pkg::S_FIN;
          end else begin
            state_next = pbpa_pkg::S_TH_RD;
          end
        end else if ((op == pbpa_pkg::OP_FREE || op == pbpa_pkg::OP_QUERY)
                     && off_pg < 32'(region_pages)) begin
          pg_raddr   = PIW'(off_pg);
          state_next = pbpa_pkg::S_FR_CHK;
        end else begin
          state_next = pbpa_pkg::S_FIN;
        end
      end
      pbpa_pkg::S_TH_RD: begin
        if (blk_ok(hd)) begin
          lk_raddr   = BIW'(hd);
          pg_raddr   = page_of(hd);
          state_next = pbpa_pkg::S_TH_DO;
        end else if (split_go) begin
          state_next = pbpa_pkg::S_SP_RD;
        end else if (larger_go) begin
          state_next = pbpa_pkg::S_TH_RD;
        end else begin
          state_next = pbpa_pkg::S_FIN;
        end
      end
      pbpa_pkg::S_TH_DO: begin
        // unlink the head block and count it out of its page
        nx_we    = blk_ok(pd);
        nx_waddr = BIW'(pd);
        nx_wdata = nd;
        pv_we    = blk_ok(nd);
        pv_waddr = BIW'(nd);
        pv_wdata = pd;
        pg_we    = 1'b1;
        pg_wdata = {pr_cls, (pr_cnt != '0) ? CW'(pr_cnt - 1'b1) : pr_cnt, pr_link};
        state_next = pbpa_pkg::S_FIN;
      end
      pbpa_pkg::S_SP_RD: begin
        pg_raddr   = PIW'(fph);
        state_next = pbpa_pkg::S_SP_SET;
      end
      pbpa_pkg::S_SP_SET: begin
        pg_we      = 1'b1;
        pg_wdata   = {csz, CW'(32'(BPP) >> thk), pr_link};
        state_next = pbpa_pkg::S_SP_PUSH;
      end
      pbpa_pkg::S_SP_PUSH: begin
        // append one block of the new page
        pv_we    = 1'b1;
        pv_waddr = BIW'(blk);
        pv_wdata = tl;
        nx_we    = blk_ok(tl);
        nx_waddr = BIW'(tl);
        nx_wdata = blk;
        if (cnt == CW'(n - 1'b1)) state_next = pbpa_pkg::S_SP_END;
      end
      pbpa_pkg::S_SP_END: begin
        nx_we      = 1'b1;
        nx_waddr   = BIW'(tl);
        nx_wdata   = NO_BLK;
        state_next = pbpa_pkg::S_TH_RD;
      end
      pbpa_pkg::S_FR_CHK: begin
        if (op == pbpa_pkg::OP_QUERY || pr_cls == '0
            || (32'(off_in) & (32'(pr_cls) - 32'd1)) != 32'd0) begin
          state_next = pbpa_pkg::S_FIN;
        end else if (32'(pr_cnt) + 32'd1 >= fr_total) begin
          state_next = pbpa_pkg::S_WK_START;
        end else begin
          pg_we      = 1'b1;
          pg_wdata   = {pr_cls, CW'(pr_cnt + 1'b1), pr_link};
          state_next = pbpa_pkg::S_FR_PUSH1;
        end
      end
      pbpa_pkg::S_FR_PUSH1: begin
        nx_we    = 1'b1;
        nx_waddr = BIW'(cur);
        nx_wdata = NO_BLK;
        pv_we    = 1'b1;
        pv_waddr = BIW'(cur);
        pv_wdata = tl;
        state_next = blk_ok(tl) ? pbpa_pkg::S_FR_PUSH2 : pbpa_pkg::S_FIN;
      end
      pbpa_pkg::S_FR_PUSH2: begin
        nx_we      = 1'b1;
        nx_waddr   = BIW'(pp);
        nx_wdata   = cur;
        state_next = pbpa_pkg::S_FIN;
      end
      pbpa_pkg::S_WK_START: begin
        state_next = pbpa_pkg::S_WK_RD;
      end
      pbpa_pkg::S_WK_RD: begin
        if (blk_ok(wcur) && 32'(steps) < 32'(TOTAL)) begin
          lk_raddr   = BIW'(wcur);
          state_next = pbpa_pkg::S_WK_DO;
        end else begin
          state_next = pbpa_pkg::S_WK_END;
        end
      end
      pbpa_pkg::S_WK_DO: begin
        // unlink blocks that lie in the page being returned
        if (page_of(wcur) == pg) begin
          nx_we    = blk_ok(pd);
          nx_waddr = BIW'(pd);
          nx_wdata = nd;
          pv_we    = blk_ok(nd);
          pv_waddr = BIW'(nd);
          pv_wdata = pd;
        end
        state_next = pbpa_pkg::S_WK_RD;
      end
      pbpa_pkg::S_WK_END: begin
        pg_we      = 1'b1;
        pg_wdata   = {SW'(0), CW'(0), fph};
        state_next = pbpa_pkg::S_FIN;
      end
      pbpa_pkg::S_FIN: begin
        if (!rsp_valid || rsp.ready) state_next = pbpa_pkg::S_IDLE;
      end
      default: state_next = pbpa_pkg::S_IDLE;
    endcase
  end

  // working registers and list heads
  always_ff @(posedge clk) begin
    pg_ridx <= pg_raddr;
    case (state)
      pbpa_pkg::S_IDLE: begin
        if (req.valid) begin
          op   <= req.opcode;
          size <= req.request_size;
          addr <= req.address;
        end
      end
      pbpa_pkg::S_DECODE: begin
        res_addr <= '0;
        res_size <= '0;
        status   <= pbpa_pkg::ST_INVALID;
        if (op == pbpa_pkg::OP_ALLOC) begin
          if (size == '0) status <= pbpa_pkg::ST_ZERO;
          if (32'(size) <= 32'(MAX_BLOCK) && size != '0) begin
            thk      <= dec_k;
            csz      <= dec_c;
            lsz      <= dec_c;
            res_size <= dec_c;
            phase    <= pbpa_pkg::PH_FIRST;
          end
        end else begin
          pg <= PIW'(off_pg);
        end
      end
      pbpa_pkg::S_TH_RD: begin
        if (blk_ok(hd)) begin
          cur <= hd;
          pg  <= page_of(hd);
        end else if (split_go) begin
          pg <= PIW'(fph);
        end else if (larger_go) begin
          thk   <= KW'(32'(thk) + 32'd1);
          lsz   <= SW'(lsz << 1);
          phase <= pbpa_pkg::PH_LARGER;
        end else begin
          status <= pbpa_pkg::ST_NOFREE;
        end
      end
      pbpa_pkg::S_TH_DO: begin
        if (!blk_ok(pd)) head[thk] <= nd;
        if (!blk_ok(nd)) tail[thk] <= pd;
        res_addr <= region_start + (32'(cur) << LOGMIN);
        status   <= pbpa_pkg::ST_OK;
        if (phase == pbpa_pkg::PH_LARGER) res_size <= lsz;
      end
      pbpa_pkg::S_SP_SET: begin
        fph    <= pr_link;
        cnt    <= '0;
        n      <= CW'(32'(BPP) >> thk);
        blk    <= BW'(pg) << LOGBPP;
        stride <= BW'(1) << thk;
      end
      pbpa_pkg::S_SP_PUSH: begin
        if (!blk_ok(tl)) head[thk] <= blk;
        tail[thk] <= blk;
        blk       <= blk + stride;
        cnt       <= cnt + 1'b1;
      end
      pbpa_pkg::S_SP_END: begin
        phase <= pbpa_pkg::PH_SPLIT;
      end
      pbpa_pkg::S_FR_CHK: begin
        res_size <= pr_cls;
        if (op == pbpa_pkg::OP_QUERY) begin
          status <= pbpa_pkg::ST_OK;
        end else if (pr_cls == '0) begin
          res_size <= '0;
        end else if ((32'(off_in) & (32'(pr_cls) - 32'd1)) == 32'd0) begin
          status <= pbpa_pkg::ST_OK;
          thk    <= fr_k;
          cur    <= (BW'(pg) << LOGBPP) | BW'(off_in >> LOGMIN);
        end
      end
      pbpa_pkg::S_FR_PUSH1: begin
        pp        <= tl;
        tail[thk] <= cur;
        if (!blk_ok(tl)) head[thk] <= cur;
      end
      pbpa_pkg::S_WK_START: begin
        wcur  <= hd;
        steps <= '0;
      end
      pbpa_pkg::S_WK_DO: begin
        if (page_of(wcur) == pg) begin
          if (!blk_ok(pd)) head[thk] <= nd;
          if (!blk_ok(nd)) tail[thk] <= pd;
        end
        wcur  <= nd;
        steps <= steps + 1'b1;
      end
      pbpa_pkg::S_WK_END: begin
        fph <= PW'(pg);
      end
      default: begin
      end
    endcase

    // page valid bits follow every record write
    if (pg_we) pg_vld[pg_waddr] <= 1'b1;

    // output register
    if (rsp_load) begin
      rsp_valid  <= 1'b1;
      out_addr   <= res_addr;
      out_size   <= pbpa_pkg::BLOCK_SIZE_W'(res_size);
      out_status <= status;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end

    // configuration write rebuilds every table
    if (cfg.valid && (cfg.index == pbpa_pkg::REG_REGION_START
                      || cfg.index == pbpa_pkg::REG_REGION_PAGES)) begin
      if (cfg.index == pbpa_pkg::REG_REGION_START) region_start <= cfg.data;
      else region_pages <= cfg_pages;
      pg_vld <= '0;
      fph    <= (rb_pages != '0) ? PW'(0) : NO_PG;
      for (int i = 0; i < NCLASS; i++) begin
        head[i] <= NO_BLK;
        tail[i] <= NO_BLK;
      end
    end

    if (rst) begin
      region_start <= '0;
      region_pages <= '0;
      pg_vld       <= '0;
      fph          <= NO_PG;
      rsp_valid    <= 1'b0;
      for (int i = 0; i < NCLASS; i++) begin
        head[i] <= NO_BLK;
        tail[i] <= NO_BLK;
      end
    end
  end

  // checks
  `PBPA_ASSERT_ALWAYS(a_fph_range, clk, rst, fph <= NO_PG, "free-page head out of range")
  `PBPA_ASSERT(a_split_count, clk, rst, (state == pbpa_pkg::S_SP_PUSH) |-> (cnt < n), "split overran page")
  `PBPA_ASSERT(a_rsp_from_fin, clk, rst, $rose(rsp_valid) |-> ($past(state) == pbpa_pkg::S_FIN), "result loaded outside finish")

endmodule

`default_nettype wire
